// ===== rtl/tkek_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkek_pkg
// Shared types and constants for the top-k edge keeper.
// ---------------------------------------------------------------------------
package tkek_pkg;

  localparam int PROB_W       = 16;
  localparam int EDGE_ID_W    = 16;
  localparam int KEEP_W       = 11;
  localparam int MAX_KEEP_DEF = 1024;
  localparam int ID_BITS_DEF  = 16;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1024;

  typedef struct packed {
    logic                 start_pass;
    logic [EDGE_ID_W-1:0] edge_id;
    logic [PROB_W-1:0]    edge_probability;
  } in_t;

  typedef struct packed {
    logic [EDGE_ID_W-1:0] evicted_id;
    logic [PROB_W-1:0]    evicted_probability;
  } out_t;

endpackage

// ===== rtl/top_k_edge_keeper_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_k_edge_keeper_top
// Keeps the keep_count highest-probability edges in a min-heap held in RAM;
// reports the edge evicted once the kept set is full.
// ---------------------------------------------------------------------------
//  port group | dir | handshake          | payload
//  in_*       | in  | in_valid/in_ready  | tkek_pkg::in_t
//  out_*      | out | out_valid/out_ready| tkek_pkg::out_t
//  cfg_*      | in  | cfg_we             | keep_count (11 bits)
//
//  Insert below capacity: accept, then for each parent compared a read and
//  a compare/write, and a final write if the entry reaches the root.
//  Full set: root read on accept, then a compare, then per level of
//  sift-down a left read, a right read and a compare/write (left read and
//  compare/write where only a left child exists), and a final write at a leaf.
//  The single RAM read port is why the two children are read in turn.
//  Reset clears heap size and sets keep_count to 1024; RAM is not cleared.
//  A result waiting in the output register stalls only the next eviction.
// ---------------------------------------------------------------------------
module top_k_edge_keeper_top #(
  parameter int MAX_KEEP = tkek_pkg::MAX_KEEP_DEF,
  parameter int ID_BITS  = tkek_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tkek_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tkek_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [tkek_pkg::KEEP_W-1:0] cfg_wdata
);

  localparam int PW    = tkek_pkg::PROB_W;
  localparam int ENT_W = PW + ID_BITS;
  localparam int AW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int SZ_W  = $clog2(MAX_KEEP + 1);
  localparam int IW    = AW + 2;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP     = 3'd1;
  localparam logic [2:0] ST_UP_CMP = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_EVICT  = 3'd4;
  localparam logic [2:0] ST_DN     = 3'd5;
  localparam logic [2:0] ST_DN_R   = 3'd6;
  localparam logic [2:0] ST_DN_CMP = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [SZ_W-1:0]             size_r, size_nxt;
  logic [AW-1:0]               at_r, at_nxt;
  logic [ENT_W-1:0]            item_r, item_nxt;
  logic [ENT_W-1:0]            lchild_r, lchild_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tkek_pkg::out_t              out_data_r, out_data_nxt;
  logic [tkek_pkg::KEEP_W-1:0] keep_r;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;

  logic [SZ_W-1:0]  cap, size_eff;
  logic [IW-1:0]    left, right;
  logic [AW-1:0]    parent;
  logic [ENT_W-1:0] in_ent, cand;
  logic [AW-1:0]    cand_idx;
  logic             out_free;

  tkek_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_KEEP)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [PW-1:0] ent_p(input logic [ENT_W-1:0] e);
    return e[ENT_W-1 -: PW];
  endfunction

  function automatic tkek_pkg::out_t ent_out(input logic [ENT_W-1:0] e);
    tkek_pkg::out_t o;
    o.evicted_id          = 16'(32'(e[ID_BITS-1:0]));
    o.evicted_probability = e[ENT_W-1 -: PW];
    return o;
  endfunction

  assign cap      = (32'(keep_r) > MAX_KEEP) ? SZ_W'(MAX_KEEP) : SZ_W'(keep_r);
  assign size_eff = in_data.start_pass ? '0 : size_r;
  assign in_ent   = {in_data.edge_probability, ID_BITS'(32'(in_data.edge_id))};
  assign left     = (IW'(at_r) << 1) + IW'(1);
  assign right    = left + IW'(1);
  assign parent   = (at_r - AW'(1)) >> 1;
  assign out_free = !out_valid_r || out_ready;

  // Child picked for the sift-down compare; left wins ties.
  always_comb begin
    if (state_r == ST_DN_CMP && ent_p(rdata) < ent_p(lchild_r)) begin
      cand     = rdata;
      cand_idx = right[AW-1:0];
    end else if (state_r == ST_DN_CMP) begin
      cand     = lchild_r;
      cand_idx = left[AW-1:0];
    end else begin
      cand     = rdata;
      cand_idx = left[AW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    at_nxt        = at_r;
    item_nxt      = item_r;
    lchild_nxt    = lchild_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = at_r;
    wdata         = item_r;
    re            = 1'b0;
    raddr         = '0;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_ent;
          if (size_eff < cap) begin
            size_nxt  = size_eff + SZ_W'(1);
            at_nxt    = AW'(size_eff);
            state_nxt = ST_UP;
          end else begin
            size_nxt = size_eff;
            if (size_eff == '0) begin
              state_nxt = ST_EVICT;
            end else begin
              re        = 1'b1;
              state_nxt = ST_ROOT;
            end
          end
        end
      end
      ST_UP: begin
        if (at_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (ent_p(item_r) < ent_p(rdata)) begin
          wdata     = rdata;
          at_nxt    = parent;
          state_nxt = ST_UP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        // rdata holds the root while the output register is busy
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ent_p(item_r) <= ent_p(rdata)) begin
            out_data_nxt = ent_out(item_r);
            state_nxt    = ST_IDLE;
          end else begin
            out_data_nxt = ent_out(rdata);
            at_nxt       = '0;
            state_nxt    = ST_DN;
          end
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ent_out(item_r);
          state_nxt     = ST_IDLE;
        end
      end
      ST_DN: begin
        if (left >= IW'(size_r)) begin
          we        = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = left[AW-1:0];
          state_nxt = ST_DN_R;
        end
      end
      ST_DN_R, ST_DN_CMP: begin
        if (state_r == ST_DN_R && right < IW'(size_r)) begin
          lchild_nxt = rdata;
          re         = 1'b1;
          raddr      = right[AW-1:0];
          state_nxt  = ST_DN_CMP;
        end else begin
          we = 1'b1;
          if (ent_p(cand) < ent_p(item_r)) begin
            wdata     = cand;
            at_nxt    = cand_idx;
            state_nxt = ST_DN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
      keep_r      <= tkek_pkg::KEEP_RESET;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    at_r       <= at_nxt;
    item_r     <= item_nxt;
    lchild_r   <= lchild_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(size_r) <= MAX_KEEP)
    else $error("heap size above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (SZ_W + 1)'(waddr) < (SZ_W + 1)'(size_r))
    else $error("heap write outside kept set");

  a_read_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> (SZ_W + 1)'(raddr) < (SZ_W + 1)'(size_nxt))
    else $error("heap read outside kept set");

  a_size_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (size_r == $past(size_r)))
    else $error("heap size changed during a sift");

endmodule

// ===== rtl/tkek_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkek_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tkek_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/top_k_edge_keeper_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_k_edge_keeper_top_test
// Offers edge requests to the keeper under a sequence of keep_count settings.
// A min-heap copy of the kept set predicts every evicted edge, and each one
// the block reports is compared in order. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module top_k_edge_keeper_top_test;
  import tkek_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int SETTLE_CYC  = 64;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef logic [PROB_W-1:0]    prob_t;
  typedef logic [EDGE_ID_W-1:0] edge_id_t;

  class eviction_board;
    prob_t            kept_prob [MAX_KEEP_DEF];
    edge_id_t         kept_id   [MAX_KEEP_DEF];
    int unsigned      kept_count;
    int unsigned      keep_limit;
    out_t             evictions_due[$];
    int               errors;

    function new();
      kept_count = 0;
      keep_limit = KEEP_RESET;
      errors     = 0;
    endfunction

    function int pending();
      return evictions_due.size();
    endfunction

    function void rise_from(int unsigned at);
      prob_t       p;
      edge_id_t    id;
      int unsigned up;
      p  = kept_prob[at];
      id = kept_id[at];
      while (at > 0) begin
        up = (at - 1) / 2;
        if (!(p < kept_prob[up])) break;
        kept_prob[at] = kept_prob[up];
        kept_id[at]   = kept_id[up];
        at = up;
      end
      kept_prob[at] = p;
      kept_id[at]   = id;
    endfunction

    // left child wins ties; swap only on strictly smaller
    function void fall_from(int unsigned at);
      prob_t       p;
      edge_id_t    id;
      int unsigned kid;
      p  = kept_prob[at];
      id = kept_id[at];
      while (2 * at + 1 < kept_count) begin
        kid = 2 * at + 1;
        if (kid + 1 < kept_count && kept_prob[kid + 1] < kept_prob[kid]) kid++;
        if (!(kept_prob[kid] < p)) break;
        kept_prob[at] = kept_prob[kid];
        kept_id[at]   = kept_id[kid];
        at = kid;
      end
      kept_prob[at] = p;
      kept_id[at]   = id;
    endfunction

    function void note_request(in_t r);
      int unsigned cap;
      out_t        ev;
      cap = (keep_limit > MAX_KEEP_DEF) ? MAX_KEEP_DEF : keep_limit;
      if (r.start_pass) kept_count = 0;
      if (kept_count < cap) begin
        kept_prob[kept_count] = r.edge_probability;
        kept_id[kept_count]   = r.edge_id;
        kept_count++;
        rise_from(kept_count - 1);
        return;
      end
      // full (or over-full after a lowered keep_count): one edge leaves
      if (kept_count == 0 || r.edge_probability <= kept_prob[0]) begin
        ev.evicted_id          = r.edge_id;
        ev.evicted_probability = r.edge_probability;
      end else begin
        ev.evicted_id          = kept_id[0];
        ev.evicted_probability = kept_prob[0];
        kept_prob[0] = r.edge_probability;
        kept_id[0]   = r.edge_id;
        fall_from(0);
      end
      evictions_due.push_back(ev);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (evictions_due.size() == 0) begin
        report($sformatf("eviction with none due: id=%h prob=%h",
                         got.evicted_id, got.evicted_probability));
        return;
      end
      want = evictions_due.pop_front();
      if (got.evicted_id !== want.evicted_id)
        report($sformatf("evicted_id %h, want %h", got.evicted_id, want.evicted_id));
      if (got.evicted_probability !== want.evicted_probability)
        report($sformatf("evicted_probability %h, want %h",
                         got.evicted_probability, want.evicted_probability));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_we;
  logic [KEEP_W-1:0]   cfg_wdata;

  eviction_board board = new();
  bit            calm;
  int            requests_sent;

  always #1 clk = ~clk;

  top_k_edge_keeper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // bias toward tiny values so ties at the heap minimum are common
  function automatic prob_t pick_prob();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return prob_t'($urandom_range(0, 7));
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return prob_t'(1);
        default: return prob_t'(16'hFFFE);
      endcase
    end
    return prob_t'($urandom);
  endfunction

  task automatic send_edge(input logic s, input edge_id_t id, input prob_t p);
    int  gap;
    in_t r;
    r.start_pass       = s;
    r.edge_id          = id;
    r.edge_probability = p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    requests_sent++;
  endtask

  // only while idle: every eviction out, then room for a trailing sift
  task automatic write_keep(input logic [KEEP_W-1:0] k);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wdata <= k;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.keep_limit = k;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 65) return KEEP_W'($urandom_range(1, 16));
    if (r < 85) return KEEP_W'($urandom_range(17, 128));
    if (r < 92) return KEEP_W'(MAX_KEEP_DEF);
    if (r < 96) return '1;
    return KEEP_W'($urandom_range(MAX_KEEP_DEF + 1, 2046));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin : result_sink
    int hold;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = calm ? 50 : $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_len;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    calm          = 1'b0;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keep_count: fill a few, no evictions
    send_edge(1'b1, 16'h0000, 16'h0000);
    send_edge(1'b0, 16'hFFFF, 16'hFFFF);
    send_edge(1'b0, 16'h1234, 16'h8000);
    send_edge(1'b0, 16'hABCD, 16'h0001);
    send_edge(1'b0, 16'h5555, 16'hFFFE);
    send_edge(1'b0, 16'hAAAA, 16'h7FFF);

    // keep_count dropped to zero with six kept: set does not shrink until a new pass starts
    write_keep('0);
    send_edge(1'b0, 16'h0101, 16'h0000);
    send_edge(1'b0, 16'h0202, 16'h9000);
    send_edge(1'b1, 16'h0303, 16'hFFFF);

    // ties at the minimum
    write_keep(KEEP_W'(3));
    send_edge(1'b1, 16'h0001, 16'h0005);
    send_edge(1'b0, 16'h0002, 16'h0005);
    send_edge(1'b0, 16'h0003, 16'h0005);
    send_edge(1'b0, 16'h0004, 16'h0005);
    send_edge(1'b0, 16'h0005, 16'h0006);
    send_edge(1'b0, 16'h0006, 16'hFFFF);
    send_edge(1'b0, 16'h0007, 16'h0000);
    send_edge(1'b0, 16'h0008, 16'h0006);

    // above capacity behaves as the full store
    write_keep('1);
    send_edge(1'b1, 16'hFFFF, 16'hFFFF);
    send_edge(1'b0, 16'h0000, 16'h0000);
    send_edge(1'b0, 16'h00FF, 16'hFF00);

    write_keep(KEEP_W'(1));
    send_edge(1'b1, 16'h8001, 16'h4000);
    send_edge(1'b0, 16'h8002, 16'h4001);
    send_edge(1'b0, 16'h8003, 16'h4001);

    while (requests_sent < ITEM_TARGET) begin
      write_keep(pick_keep());
      calm      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 150);
      for (int j = 0; j < phase_len; j++) begin
        send_edge((j == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 63) == 0,
                  edge_id_t'($urandom), pick_prob());
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
